// ----- rtl/jse_pkg.sv -----
// Shared types, codes and helper functions of the JSON string escaper.
package jse_pkg;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CTRL_END  = 8'h20;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_A_LOWER   = 8'h61;

    // Body kinds: how a character is written inside the literal.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PLAIN = 2'd1;
    localparam logic [1:0] KIND_SHORT = 2'd2;
    localparam logic [1:0] KIND_UNI   = 2'd3;

    // Output slots: opening quote, up to six body bytes, closing quote.
    localparam logic [2:0] POS_OPEN  = 3'd0;
    localparam logic [2:0] POS_BODY  = 3'd1;
    localparam logic [2:0] POS_CLOSE = 3'd7;

    localparam logic [2:0] LEN_PLAIN = 3'd1;
    localparam logic [2:0] LEN_SHORT = 3'd2;
    localparam logic [2:0] LEN_UNI   = 3'd6;

    // One classified item. For the short kind, ch holds the escape letter.
    typedef struct packed {
        logic       first;
        logic       last;
        logic [1:0] kind;
        logic [7:0] ch;
    } t_desc;

    typedef struct packed {
        logic       valid;
        logic [2:0] pos;
    } t_step;

    function automatic logic [2:0] body_len(input logic [1:0] kind);
        logic [2:0] len;
        unique case (kind)
            KIND_PLAIN: len = LEN_PLAIN;
            KIND_SHORT: len = LEN_SHORT;
            KIND_UNI:   len = LEN_UNI;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] start_pos(input t_desc d);
        logic [2:0] p;
        if (d.first) begin
            p = POS_OPEN;
        end else if (d.kind != KIND_NONE) begin
            p = POS_BODY;
        end else begin
            p = POS_CLOSE;
        end
        return p;
    endfunction

    function automatic t_step next_step(input t_desc d, input logic [2:0] pos);
        t_step      s;
        logic [2:0] len;
        len = body_len(d.kind);
        s.valid = 1'b0;
        s.pos   = POS_CLOSE;
        if (pos == POS_CLOSE) begin
            s.valid = 1'b0;
        end else if (pos < len) begin
            // Covers the opening quote followed by a body, and body bytes.
            s.valid = 1'b1;
            s.pos   = pos + 3'd1;
        end else begin
            s.valid = d.last;
        end
        return s;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'd0, nib};
        end else begin
            c = CH_A_LOWER + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

    function automatic logic [7:0] slot_byte(input t_desc d, input logic [2:0] pos);
        logic [7:0] b;
        b = CH_QUOTE;
        if (pos != POS_OPEN && pos != POS_CLOSE) begin
            unique case (d.kind)
                KIND_PLAIN: b = d.ch;
                KIND_SHORT: b = (pos == 3'd1) ? CH_BACKSLASH : d.ch;
                KIND_UNI: begin
                    unique case (pos)
                        3'd1:    b = CH_BACKSLASH;
                        3'd2:    b = CH_U;
                        3'd3:    b = CH_ZERO;
                        3'd4:    b = CH_ZERO;
                        3'd5:    b = hex_digit(d.ch[7:4]);
                        default: b = hex_digit(d.ch[3:0]);
                    endcase
                end
                default: b = CH_QUOTE;
            endcase
        end
        return b;
    endfunction

endpackage

// ----- rtl/jse_front.sv -----
// Input stage: accepts raw bytes and classifies each into an item descriptor.
module jse_front (
    input  logic            i_in_valid,
    input  logic [7:0]      i_in_byte,
    input  logic            i_first,
    input  logic            i_last,
    input  logic            i_empty_req,
    output logic            o_in_ready,
    input  logic            i_q_full,
    output logic            o_push,
    output jse_pkg::t_desc  o_desc
);

    logic [1:0] kind;
    logic [7:0] ch;
    logic       has_result;

    always_comb begin
        ch = i_in_byte;
        if (i_empty_req) begin
            kind = jse_pkg::KIND_NONE;
        end else begin
            kind = jse_pkg::KIND_SHORT;
            unique case (i_in_byte)
                jse_pkg::CH_QUOTE:     ch = jse_pkg::CH_QUOTE;
                jse_pkg::CH_BACKSLASH: ch = jse_pkg::CH_BACKSLASH;
                jse_pkg::CH_BS:        ch = jse_pkg::CH_B;
                jse_pkg::CH_FF:        ch = jse_pkg::CH_F;
                jse_pkg::CH_LF:        ch = jse_pkg::CH_N;
                jse_pkg::CH_CR:        ch = jse_pkg::CH_R;
                jse_pkg::CH_TAB:       ch = jse_pkg::CH_T;
                default: begin
                    kind = (i_in_byte < jse_pkg::CH_CTRL_END) ? jse_pkg::KIND_UNI
                                                              : jse_pkg::KIND_PLAIN;
                end
            endcase
        end
    end

    // Items that produce no bytes at all are taken and dropped here.
    assign has_result = i_first | i_last | ~i_empty_req;
    assign o_in_ready = ~i_q_full;
    assign o_push     = i_in_valid & ~i_q_full & has_result;

    assign o_desc.first = i_first;
    assign o_desc.last  = i_last;
    assign o_desc.kind  = kind;
    assign o_desc.ch    = ch;

endmodule

// ----- rtl/jse_fifo.sv -----
// Short descriptor queue between the classifier and the output sequencer.
module jse_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jse_pkg::t_desc  i_desc,
    input  logic            i_pop,
    output jse_pkg::t_desc  o_desc,
    output logic            o_full,
    output logic            o_not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jse_pkg::t_desc r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;

    assign o_full      = (r_count == CW'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_desc      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_not_empty))
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ----- rtl/jse_back.sv -----
// Output sequencer: walks each descriptor's byte slots into the output register.
module jse_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jse_pkg::t_desc  i_desc,
    input  logic            i_head_valid,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_end_of_run
);

    logic           r_mid;
    logic [2:0]     r_pos;
    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_end;
    logic [2:0]     cur_pos;
    jse_pkg::t_step step;
    logic           emit;

    // While not in the middle of an item, the head's first slot is used directly.
    assign cur_pos = r_mid ? r_pos : jse_pkg::start_pos(i_desc);
    assign step    = jse_pkg::next_step(i_desc, cur_pos);
    assign emit    = i_head_valid & (~r_out_valid | i_out_ready);
    assign o_pop   = emit & ~step.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_pos       <= jse_pkg::POS_OPEN;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                r_mid       <= step.valid;
                r_pos       <= step.pos;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= jse_pkg::slot_byte(i_desc, cur_pos);
            r_out_end  <= ~step.valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_end_of_run = r_out_end;

`ifndef SYNTHESIS
    a_mid_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> i_head_valid)
        else $error("sequencer mid-item without a queued descriptor");
    a_pop_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_valid && r_out_end))
        else $error("descriptor retired without an end-of-run byte");
    a_emit_keeps_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !o_pop) |=> (r_mid && !r_out_end))
        else $error("sequencer lost its place within an item");
`endif

endmodule

// ----- rtl/json_string_escaper.sv -----
// Top level of the JSON string escaper: classifier, descriptor queue, sequencer.
//
//  Channel  Handshake                  Payload
//  input    i_in_valid / o_in_ready    i_in_byte, i_first, i_last, i_empty_req
//  output   o_out_valid / i_out_ready  o_out_byte, o_end_of_run
//
// One-byte items are accepted every cycle, back to back, while output ready is high.
// An item that makes N bytes (1 to 8) holds the sequencer until all are out; the
// queue of QUEUE_DEPTH descriptors absorbs that, then input ready drops.
// Output ready low freezes the sequencer; input keeps flowing until the queue fills.
// Reset is synchronous, active low, and empties the queue and output register.
module json_string_escaper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_first,
    input  logic       i_last,
    input  logic       i_empty_req,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_run
);

    jse_pkg::t_desc push_desc;
    jse_pkg::t_desc head_desc;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_not_empty;

    jse_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in_byte   (i_in_byte),
        .i_first     (i_first),
        .i_last      (i_last),
        .i_empty_req (i_empty_req),
        .o_in_ready  (o_in_ready),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    jse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_desc      (push_desc),
        .i_pop       (pop),
        .o_desc      (head_desc),
        .o_full      (q_full),
        .o_not_empty (q_not_empty)
    );

    jse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (head_desc),
        .i_head_valid (q_not_empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_end_of_run (o_end_of_run)
    );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the JSON string escaper with random handshake idling.
module tb;

    localparam int HOLD_LEN   = 150;
    localparam int HOLD_AT_A  = 30;
    localparam int HOLD_AT_B  = 200;
    localparam int RAND_ITEMS = 125;
    localparam int DRAIN_CYC  = 30;

    typedef struct {
        logic [7:0] chr;
        logic       open_mark;
        logic       close_mark;
        logic       no_char;
    } t_str_item;

    typedef struct {
        logic [7:0] chr;
        logic       eor;
    } t_lit_byte;

    logic       i_clk;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_in_byte    = 8'h00;
    logic       i_first      = 1'b0;
    logic       i_last       = 1'b0;
    logic       i_empty_req  = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready  = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_end_of_run;

    t_str_item  pending_q[$];
    t_lit_byte  literal_q[$];

    logic live     = 1'b0;
    logic in_xfer  = 1'b0;
    logic out_xfer = 1'b0;

    int n_errors    = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_escapes   = 0;
    int n_stalled   = 0;
    int n_strings   = 0;
    int hold_left   = 0;
    int rx_seen     = 0;

    json_string_escaper DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_first      (i_first),
        .i_last       (i_last),
        .i_empty_req  (i_empty_req),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_end_of_run (o_end_of_run)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] hex_lower(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = jse_pkg::CH_ZERO + {4'd0, nib};
        end else begin
            c = jse_pkg::CH_A_LOWER + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

    // Appends the escaped literal bytes that one accepted string item must produce.
    task automatic predict_literal(input t_str_item it);
        t_lit_byte  seq[$];
        t_lit_byte  lb;
        logic [7:0] code;
        code = 8'h00;
        lb.eor = 1'b0;
        if (it.open_mark) begin
            lb.chr = jse_pkg::CH_QUOTE;
            seq.insert(seq.size(), lb);
        end
        if (!it.no_char) begin
            case (it.chr)
                jse_pkg::CH_QUOTE:     code = jse_pkg::CH_QUOTE;
                jse_pkg::CH_BACKSLASH: code = jse_pkg::CH_BACKSLASH;
                jse_pkg::CH_BS:        code = jse_pkg::CH_B;
                jse_pkg::CH_FF:        code = jse_pkg::CH_F;
                jse_pkg::CH_LF:        code = jse_pkg::CH_N;
                jse_pkg::CH_CR:        code = jse_pkg::CH_R;
                jse_pkg::CH_TAB:       code = jse_pkg::CH_T;
                default:               code = 8'h00;
            endcase
            if (code != 8'h00) begin
                lb.chr = jse_pkg::CH_BACKSLASH;
                seq.insert(seq.size(), lb);
                lb.chr = code;
                seq.insert(seq.size(), lb);
                n_escapes++;
            end else if (it.chr < jse_pkg::CH_CTRL_END) begin
                lb.chr = jse_pkg::CH_BACKSLASH;
                seq.insert(seq.size(), lb);
                lb.chr = jse_pkg::CH_U;
                seq.insert(seq.size(), lb);
                lb.chr = jse_pkg::CH_ZERO;
                seq.insert(seq.size(), lb);
                seq.insert(seq.size(), lb);
                lb.chr = hex_lower(it.chr[7:4]);
                seq.insert(seq.size(), lb);
                lb.chr = hex_lower(it.chr[3:0]);
                seq.insert(seq.size(), lb);
                n_escapes++;
            end else begin
                lb.chr = it.chr;
                seq.insert(seq.size(), lb);
            end
        end
        if (it.close_mark) begin
            lb.chr = jse_pkg::CH_QUOTE;
            seq.insert(seq.size(), lb);
        end
        if (seq.size() > 0) begin
            seq[seq.size() - 1].eor = 1'b1;
        end
        foreach (seq[k]) begin
            literal_q.insert(literal_q.size(), seq[k]);
        end
    endtask

    task automatic check_literal_byte();
        t_lit_byte exp_b;
        if (literal_q.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected output byte %h eor %b, nothing expected",
                     $time, o_out_byte, o_end_of_run);
        end else begin
            exp_b = literal_q.pop_front();
            if (o_out_byte !== exp_b.chr) begin
                n_errors++;
                $display("%0t: out_byte mismatch, expected %h actual %h",
                         $time, exp_b.chr, o_out_byte);
            end
            if (o_end_of_run !== exp_b.eor) begin
                n_errors++;
                $display("%0t: end_of_run mismatch, expected %b actual %b",
                         $time, exp_b.eor, o_end_of_run);
            end
        end
        n_checked++;
    endtask

    // Idle cycles before the next transfer; now and then a calm stretch with no idling.
    function automatic int idle_draw(inout int calm);
        int r;
        int gap;
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                gap = 0;
            end else if (r < 8) begin
                gap = $urandom_range(1, 4);
            end else begin
                gap = $urandom_range(0, 19);
            end
            if ($urandom_range(0, 31) == 0) begin
                calm = $urandom_range(10, 40);
            end
        end
        return gap;
    endfunction

    function automatic logic [7:0] pick_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            c = 8'($urandom_range(32'h20, 32'h7E));
        end else if (r < 60) begin
            c = 8'($urandom_range(0, 31));
        end else if (r < 70) begin
            c = ($urandom_range(0, 1) != 0) ? jse_pkg::CH_QUOTE : jse_pkg::CH_BACKSLASH;
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    task automatic add_item(input logic [7:0] c, input logic o, input logic cl,
                            input logic e);
        t_str_item it;
        it.chr        = c;
        it.open_mark  = o;
        it.close_mark = cl;
        it.no_char    = e;
        pending_q.insert(pending_q.size(), it);
    endtask

    // Sampling side: transfers, prediction and checking all happen at the rising edge.
    always @(posedge i_clk) begin
        live     <= i_rst_n;
        in_xfer  <= i_rst_n && i_in_valid && o_in_ready;
        out_xfer <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_literal('{i_in_byte, i_first, i_last, i_empty_req});
            n_sent++;
        end
        if (i_rst_n && i_in_valid && !o_in_ready) begin
            n_stalled++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_literal_byte();
        end
    end

    // Long receiver hold-off so that the queue inside the block fills up.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (i_rst_n && o_out_valid && i_out_ready) begin
            rx_seen <= rx_seen + 1;
            if (rx_seen + 1 == HOLD_AT_A || rx_seen + 1 == HOLD_AT_B) begin
                hold_left <= HOLD_LEN;
            end
        end
    end

    // Sender: presents pending items at the falling edge.
    int tx_wait = 0;
    int tx_calm = 0;
    always @(negedge i_clk) begin
        logic      nxt_valid;
        t_str_item it;
        nxt_valid = i_in_valid;
        if (in_xfer) begin
            nxt_valid = 1'b0;
            tx_wait   = idle_draw(tx_calm);
        end
        if (live && !nxt_valid) begin
            if (tx_wait > 0) begin
                tx_wait--;
            end else if (pending_q.size() > 0) begin
                it = pending_q.pop_front();
                i_in_byte   <= it.chr;
                i_first     <= it.open_mark;
                i_last      <= it.close_mark;
                i_empty_req <= it.no_char;
                nxt_valid = 1'b1;
            end
        end
        i_in_valid <= nxt_valid;
    end

    // Receiver: ready drops for a drawn number of cycles after each transfer.
    int rx_wait = 0;
    int rx_calm = 0;
    always @(negedge i_clk) begin
        logic nxt_ready;
        if (out_xfer) begin
            rx_wait = idle_draw(rx_calm);
        end
        if (!live || hold_left > 0) begin
            nxt_ready = 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            nxt_ready = 1'b0;
        end else begin
            nxt_ready = 1'b1;
        end
        i_out_ready <= nxt_ready;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int n_random;
        int len;
        logic [7:0] c;

        // Directed part: framing corner cases and every escape class.
        add_item(8'h41, 1'b1, 1'b1, 1'b1);          // empty string
        add_item(8'hFF, 1'b0, 1'b0, 1'b1);          // empty item, no marks
        add_item(8'h00, 1'b0, 1'b0, 1'b1);
        add_item(8'h5A, 1'b1, 1'b0, 1'b1);          // opening quote only
        add_item(8'hA5, 1'b0, 1'b1, 1'b1);          // closing quote only
        add_item(8'h01, 1'b1, 1'b1, 1'b0);          // longest literal
        add_item(8'h00, 1'b1, 1'b0, 1'b0);
        add_item(jse_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0);
        add_item(jse_pkg::CH_BACKSLASH, 1'b0, 1'b0, 1'b0);
        add_item(jse_pkg::CH_BS, 1'b0, 1'b0, 1'b0);
        add_item(jse_pkg::CH_FF, 1'b0, 1'b0, 1'b0);
        add_item(jse_pkg::CH_LF, 1'b0, 1'b0, 1'b0);
        add_item(jse_pkg::CH_CR, 1'b0, 1'b0, 1'b0);
        add_item(jse_pkg::CH_TAB, 1'b0, 1'b0, 1'b0);
        add_item(8'h1F, 1'b0, 1'b0, 1'b0);
        add_item(8'h1B, 1'b0, 1'b0, 1'b0);
        add_item(8'h0B, 1'b0, 1'b0, 1'b0);
        add_item(jse_pkg::CH_CTRL_END, 1'b0, 1'b0, 1'b0);
        add_item(8'h7F, 1'b0, 1'b0, 1'b0);
        add_item(8'h80, 1'b0, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b1, 1'b0);
        // Framing misuse: closing without opening, opening twice.
        add_item(8'h41, 1'b0, 1'b1, 1'b0);
        add_item(8'h42, 1'b1, 1'b0, 1'b0);
        add_item(8'h1A, 1'b1, 1'b0, 1'b0);
        add_item(jse_pkg::CH_QUOTE, 1'b1, 1'b1, 1'b0);

        // Random part: mostly well-formed strings, some loose noise items.
        n_random = 0;
        while (n_random < RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                if (pending_q[pending_q.size() - 1].open_mark ||
                    pending_q[pending_q.size() - 1].close_mark ||
                    !pending_q[pending_q.size() - 1].no_char) begin
                    n_random++;
                end
            end else begin
                len = $urandom_range(0, 8);
                n_strings++;
                if (len == 0) begin
                    add_item(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b1);
                    n_random++;
                end
                for (int k = 0; k < len; k++) begin
                    c = pick_char();
                    add_item(c, k == 0, k == len - 1, 1'b0);
                    n_random++;
                end
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (pending_q.size() != 0 || i_in_valid || literal_q.size() != 0);
        repeat (DRAIN_CYC) @(negedge i_clk);

        $display("Sent %0d items (%0d random strings), checked %0d literal bytes, %0d escapes.",
                 n_sent, n_strings, n_checked, n_escapes);
        $display("Input was held back for %0d cycles under output stalls.", n_stalled);
        if (n_errors == 0 && literal_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
